@@ hw/rtl/deq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue: operation codes,
// field widths and the command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEQ_DEPTH_DEFAULT = 16;

   localparam int VALUE_WIDTH   = 32;
   localparam int KIND_WIDTH    = 2;
   localparam int ENTRIES_WIDTH = 5;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_PUSH_FRONT = 2'd0,
      KIND_PUSH_REAR  = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_REAR   = 2'd3
   } kind_type;

   // Command from the controller: load strobes the operation into the
   // datapath at the edge where the request transfer completes.
   typedef struct packed {
      logic load;
   } deq_cmd_type;

endpackage

@@ hw/rtl/deq_channels_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_req_if / deq_rsp_if
// Valid/ready channels of the double-ended queue: the operation request and
// the result of that operation.
// ----------------------------------------------------------------------------
interface deq_req_if
   import deq_pkg::*;
   ();
   logic                          valid;
   logic                          ready;
   logic [KIND_WIDTH-1:0]         kind;
   logic signed [VALUE_WIDTH-1:0] push_value;

   modport source (output valid, output kind, output push_value, input ready);
   modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface deq_rsp_if
   import deq_pkg::*;
   ();
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] pop_value;
   logic                          was_empty;
   logic                          was_full;
   logic                          now_empty;
   logic [ENTRIES_WIDTH-1:0]      entries;

   modport source (output valid, output pop_value, output was_empty, output was_full,
                   output now_empty, output entries, input ready);
   modport sink   (input valid, input pop_value, input was_empty, input was_full,
                   input now_empty, input entries, output ready);
endinterface

@@ hw/rtl/deq_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_controller
// Two-state handshake sequencer: takes one request, then holds the result
// until the result transfer completes.
// ----------------------------------------------------------------------------
module deq_controller
   import deq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output deq_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SEND = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_SEND);
   assign cmd.load  = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/deq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_datapath
// Ring store with front and rear indices and a fill count. At most one slot
// access per operation; the popped value comes out of the registered read port.
// ----------------------------------------------------------------------------
module deq_datapath
   import deq_pkg::*;
#(
   parameter int DEPTH = DEQ_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  deq_cmd_type                   cmd,
   input  logic [KIND_WIDTH-1:0]         kind,
   input  logic signed [VALUE_WIDTH-1:0] push_value,
   output logic signed [VALUE_WIDTH-1:0] pop_value,
   output logic                          was_empty,
   output logic                          was_full,
   output logic                          now_empty,
   output logic [ENTRIES_WIDTH-1:0]      entries
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW-1:0] LAST_INDEX = IW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [VALUE_WIDTH-1:0] mem [DEPTH];

   logic [IW-1:0]          front_ff, front_in;
   logic [IW-1:0]          rear_ff, rear_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [VALUE_WIDTH-1:0] rdata_ff;
   logic                   pop_ok_ff;
   logic                   was_empty_ff;
   logic                   was_full_ff;

   logic                   is_full;
   logic                   is_empty;
   logic [IW-1:0]          front_dec, front_inc, rear_dec, rear_inc;
   logic [IW-1:0]          addr;
   logic                   wr_en;
   logic                   rd_en;
   logic                   refuse_push;
   logic                   refuse_pop;

   assign is_full  = (count_ff == FULL_COUNT);
   assign is_empty = (count_ff == '0);

   assign front_inc = (front_ff == LAST_INDEX) ? '0 : front_ff + 1'b1;
   assign front_dec = (front_ff == '0) ? LAST_INDEX : front_ff - 1'b1;
   assign rear_inc  = (rear_ff == LAST_INDEX) ? '0 : rear_ff + 1'b1;
   assign rear_dec  = (rear_ff == '0) ? LAST_INDEX : rear_ff - 1'b1;

   always_comb begin
      front_in    = front_ff;
      rear_in     = rear_ff;
      count_in    = count_ff;
      addr        = front_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      refuse_push = 1'b0;
      refuse_pop  = 1'b0;
      unique case (kind_type'(kind))
         KIND_PUSH_FRONT: begin
            addr = front_dec;
            if (is_full) begin
               refuse_push = 1'b1;
            end else begin
               wr_en    = cmd.load;
               front_in = front_dec;
               count_in = count_ff + 1'b1;
            end
         end
         KIND_PUSH_REAR: begin
            addr = rear_ff;
            if (is_full) begin
               refuse_push = 1'b1;
            end else begin
               wr_en    = cmd.load;
               rear_in  = rear_inc;
               count_in = count_ff + 1'b1;
            end
         end
         KIND_POP_FRONT: begin
            addr = front_ff;
            if (is_empty) begin
               refuse_pop = 1'b1;
            end else begin
               rd_en    = cmd.load;
               front_in = front_inc;
               count_in = count_ff - 1'b1;
            end
         end
         KIND_POP_REAR: begin
            addr = rear_dec;
            if (is_empty) begin
               refuse_pop = 1'b1;
            end else begin
               rd_en    = cmd.load;
               rear_in  = rear_dec;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            addr = front_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= push_value;
      if (rd_en) rdata_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         rear_ff      <= '0;
         count_ff     <= '0;
         pop_ok_ff    <= 1'b0;
         was_empty_ff <= 1'b0;
         was_full_ff  <= 1'b0;
      end else if (cmd.load) begin
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         count_ff     <= count_in;
         pop_ok_ff    <= rd_en;
         was_empty_ff <= refuse_pop;
         was_full_ff  <= refuse_push;
      end
   end

   // The read register only changes on a successful pop, so it is masked
   // for pushes and refused pops.
   assign pop_value = pop_ok_ff ? rdata_ff : '0;
   assign was_empty = was_empty_ff;
   assign was_full  = was_full_ff;
   assign now_empty = (count_ff == '0);
   assign entries   = ENTRIES_WIDTH'(count_ff);

endmodule

@@ hw/rtl/double_ended_queue_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Double-ended queue of signed 32-bit values in a ring of DEPTH slots, with
// push and pop at either end and one result per operation.
// ----------------------------------------------------------------------------
//  Channel    Dir   Payload                                          Handshake
//  req_chan   in    kind, push_value                                 valid/ready
//  rsp_chan   out   pop_value, was_empty, was_full, now_empty, entries valid/ready
//
//  For each operation, the request transfer performs the slot access and index
//  update, and the result is offered from the next cycle. The controller
//  alternates between taking a request and offering its single held result.
//  A new request is taken only after the previous result transfer.
//  Synchronous reset empties the queue; slot contents are not cleared.
//  While the result is stalled the block holds it and takes no request.
// ----------------------------------------------------------------------------
module double_ended_queue_top
   import deq_pkg::*;
#(
   parameter int DEPTH = DEQ_DEPTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   deq_req_if.sink   req_chan,
   deq_rsp_if.source rsp_chan
);

   deq_cmd_type cmd;

   deq_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   deq_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .kind       (req_chan.kind),
      .push_value (req_chan.push_value),
      .pop_value  (rsp_chan.pop_value),
      .was_empty  (rsp_chan.was_empty),
      .was_full   (rsp_chan.was_full),
      .now_empty  (rsp_chan.now_empty),
      .entries    (rsp_chan.entries)
   );

   // A request is never taken while a result is still on offer.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_chan.valid && req_chan.ready))
      else $error("request taken while result pending");

   // Every request transfer is followed by a result in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> rsp_chan.valid)
      else $error("no result after request transfer");

   // One operation cannot be both a refused push and a refused pop.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.was_empty && rsp_chan.was_full))
      else $error("both refusal flags set");

   // A refused pop leaves the queue empty and returns zero.
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.was_empty) |-> (rsp_chan.now_empty &&
      rsp_chan.pop_value == '0))
      else $error("refused pop with entries or nonzero value");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for double_ended_queue_top. A scoreboard keeps its own
// ring of slots and indices, predicts one result per request transfer and
// compares every result transfer against the oldest prediction. Traffic runs
// through directed corner cases and then random fill, drain and mixed runs
// under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb;
   import deq_pkg::*;

   localparam int DEQ_DEPTH    = DEQ_DEPTH_DEFAULT;
   localparam int LIMIT_CYCLES = 200000;
   localparam int HOLD_CYCLES  = 150;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] pop_value;
      logic                          was_empty;
      logic                          was_full;
      logic                          now_empty;
      logic [ENTRIES_WIDTH-1:0]      entries;
   } deque_result_type;

   class deque_checker;
      logic signed [VALUE_WIDTH-1:0] slots [DEQ_DEPTH];
      int unsigned      front_index;
      int unsigned      rear_index;
      int unsigned      fill;
      deque_result_type pending_results[$];
      int               errors;
      int               stored;
      int               refused;
      int               popped;
      int               empty_pops;
      int unsigned      peak_fill;

      // Advances the mirrored ring by one operation and queues its result.
      function void note_request(kind_type kind, logic signed [VALUE_WIDTH-1:0] value);
         deque_result_type want;
         want = '0;
         case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
               if (fill >= DEQ_DEPTH) begin
                  want.was_full = 1'b1;
                  refused++;
               end else if (kind == KIND_PUSH_FRONT) begin
                  front_index = (front_index + DEQ_DEPTH - 1) % DEQ_DEPTH;
                  slots[front_index] = value;
                  fill++;
                  stored++;
               end else begin
                  slots[rear_index] = value;
                  rear_index = (rear_index + 1) % DEQ_DEPTH;
                  fill++;
                  stored++;
               end
            end
            default: begin
               if (fill == 0) begin
                  want.was_empty = 1'b1;
                  empty_pops++;
               end else if (kind == KIND_POP_FRONT) begin
                  want.pop_value = slots[front_index];
                  front_index = (front_index + 1) % DEQ_DEPTH;
                  fill--;
                  popped++;
               end else begin
                  rear_index = (rear_index + DEQ_DEPTH - 1) % DEQ_DEPTH;
                  want.pop_value = slots[rear_index];
                  fill--;
                  popped++;
               end
            end
         endcase
         want.now_empty = (fill == 0);
         want.entries   = ENTRIES_WIDTH'(fill);
         if (fill > peak_fill) peak_fill = fill;
         pending_results.push_back(want);
      endfunction

      function void compare_field(string field, longint want, longint got);
         if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_result(deque_result_type got);
         deque_result_type want;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected result, expected none, actual pop_value %0d entries %0d",
                     $time, got.pop_value, got.entries);
            return;
         end
         want = pending_results.pop_front();
         compare_field("pop_value", longint'(want.pop_value), longint'(got.pop_value));
         compare_field("was_empty", want.was_empty, got.was_empty);
         compare_field("was_full", want.was_full, got.was_full);
         compare_field("now_empty", want.now_empty, got.now_empty);
         compare_field("entries", want.entries, got.entries);
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count;
   int   sender_idle_pct;
   int   receiver_stall_pct;
   int   stall_left;
   int   items_sent;

   deque_checker board = new;

   deq_req_if req_if ();
   deq_rsp_if rsp_if ();

   double_ended_queue_top #(
      .DEPTH(DEQ_DEPTH)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      cycle_count = 0;
      wait (cycle_count >= LIMIT_CYCLES);
      $display("%0t ns: timed out after %0d cycles", $time, cycle_count);
      $display("== FAIL ==");
      $finish;
   end

   // Receiver: checks each result transfer and decides ready for the next
   // cycle. A requested hold keeps ready low for a counted stretch.
   initial begin
      deque_result_type got;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.pop_value = rsp_if.pop_value;
            got.was_empty = rsp_if.was_empty;
            got.was_full  = rsp_if.was_full;
            got.now_empty = rsp_if.now_empty;
            got.entries   = rsp_if.entries;
            board.check_result(got);
         end
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
      case ($urandom_range(9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return -32'sd1;
         3:       return 32'sd0;
         default: return $urandom;
      endcase
   endfunction

   function automatic kind_type pick_kind(int push_pct);
      logic at_rear;
      at_rear = 1'($urandom_range(1));
      if ($urandom_range(99) < push_pct) return at_rear ? KIND_PUSH_REAR : KIND_PUSH_FRONT;
      return at_rear ? KIND_POP_REAR : KIND_POP_FRONT;
   endfunction

   // Offers one operation and returns at the edge where its transfer completes.
   task automatic send_op(kind_type kind, logic signed [VALUE_WIDTH-1:0] value);
      int gap;
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         gap = $urandom_range(1, 3);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.kind       <= kind;
      req_if.push_value <= value;
      do @(posedge clock); while (!req_if.ready);
      board.note_request(kind, value);
      items_sent++;
   endtask

   // Sender goes quiet until every predicted result has been seen.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (board.outstanding() != 0);
   endtask

   task automatic run_directed();
      send_op(KIND_POP_FRONT, 32'sh1234_5678);
      send_op(KIND_POP_REAR, -32'sd1);
      send_op(KIND_PUSH_FRONT, 32'sh8000_0000);
      send_op(KIND_PUSH_REAR, 32'sh7FFF_FFFF);
      send_op(KIND_PUSH_FRONT, -32'sd1);
      send_op(KIND_PUSH_REAR, 32'sd0);
      for (int i = 0; i < DEQ_DEPTH - 4; i++) begin
         send_op(i[0] ? KIND_PUSH_REAR : KIND_PUSH_FRONT, $urandom);
      end
      // The queue is full now, so both pushes must be refused.
      send_op(KIND_PUSH_FRONT, 32'sh5555_5555);
      send_op(KIND_PUSH_REAR, 32'shAAAA_AAAA);
      send_op(KIND_POP_FRONT, 32'sd0);
      send_op(KIND_POP_REAR, 32'sd0);
      drain_results();
   endtask

   // Random runs that alternate between filling, draining and mixed traffic,
   // so the queue goes through full and empty often.
   task automatic run_phase(int count, int idle_pct, int stall_pct, bit with_hold);
      int push_pct;
      int run_left;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      run_left = 0;
      push_pct = 50;
      for (int i = 0; i < count; i++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(8, 40);
            case ($urandom_range(3))
               0:       push_pct = 85;
               1:       push_pct = 15;
               default: push_pct = 50;
            endcase
         end
         if (with_hold && i == count / 3) stall_left = HOLD_CYCLES;
         send_op(pick_kind(push_pct), pick_value());
         run_left--;
      end
      drain_results();
   endtask

   initial begin
      reset              = 1'b1;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      stall_left         = 0;
      items_sent         = 0;
      req_if.valid      <= 1'b0;
      req_if.kind       <= KIND_PUSH_FRONT;
      req_if.push_value <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_phase(345, 0, 0, 1'b1);
      run_phase(345, 46, 0, 1'b0);
      run_phase(345, 0, 46, 1'b0);
      run_phase(345, 18, 18, 1'b0);

      repeat (8) @(posedge clock);
      $display("Ran %0d operations: %0d pushes stored, %0d refused as full, %0d pops with data,",
               items_sent, board.stored, board.refused, board.popped);
      $display("%0d pops on empty; fill peaked at %0d of %0d, with a %0d-cycle receiver hold.",
               board.empty_pops, board.peak_fill, DEQ_DEPTH, HOLD_CYCLES);
      if (board.errors == 0 && board.outstanding() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
